### src/matrix_keypad_scan_debounce_assert.svh
// Assertion macros used by the keypad scanner checker.
`ifndef MATRIX_KEYPAD_SCAN_DEBOUNCE_ASSERT_SVH
`define MATRIX_KEYPAD_SCAN_DEBOUNCE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MKSD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MKSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/mksd_pkg.sv
// Types and fixed widths for the keypad scanner.
package mksd_pkg;

  localparam int IN_W  = 4;   // column level input width
  localparam int DRV_W = 4;   // row drive output width
  localparam int KEY_W = 5;   // key number output width
  localparam int CNT_W = 8;   // debounce counter / debounce limit width

  localparam logic [CNT_W-1:0] DEB_LIMIT_RST = 8'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILTER,
    ST_EMIT
  } st_t;

endpackage

### src/mksd_ram.sv
// Generic simple dual-port RAM with registered read.
module mksd_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/matrix_keypad_scan_debounce.sv
// Keypad matrix scanner with per-key integrating debounce, top level.
//
//  channel | ports                               | handshake
//  --------+-------------------------------------+-------------------
//  cfg     | cfg_we, cfg_wdata (debounce limit)  | write on cfg_we
//  in      | in_column_levels                    | in_valid / in_stall
//  out     | out_row_drive, out_key_number       | out_valid / out_stall
//
// A tick on rows 0..ROWS-2 stores the row samples and yields its result the
// cycle after acceptance. A tick on the last row starts a filter pass over the
// counter RAM, one key per cycle with read/modify/write pipelined over the
// RAM read latency; the result follows from the emit state after the pass.
// Reset is synchronous; per-key valid bits stand in for clearing the counter
// RAM, so no sweep follows reset. A stalled result holds the input stalled.
module matrix_keypad_scan_debounce import mksd_pkg::*; #(
  parameter int ROWS = 4,
  parameter int COLS = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [IN_W-1:0]  in_column_levels,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [DRV_W-1:0] out_row_drive,
  output logic [KEY_W-1:0] out_key_number
);

  localparam int NKEYS = ROWS * COLS;
  localparam int KA    = $clog2(NKEYS);
  localparam int RA    = $clog2(ROWS);
  localparam int CA    = $clog2(COLS);
  localparam int KW    = $clog2(NKEYS + 1);

  st_t state_r, state_nxt;

  logic [CNT_W-1:0] deb_limit_r;
  logic [RA-1:0]    row_r, row_nxt, row_inc;
  logic             last_row;

  logic             iss_busy_r, iss_busy_nxt;
  logic [KA-1:0]    iss_key_r, iss_key_nxt;
  logic [RA-1:0]    iss_row_r, iss_row_nxt;
  logic [CA-1:0]    iss_col_r, iss_col_nxt;
  logic             s1_v_r;
  logic [KA-1:0]    s1_key_r;
  logic [CA-1:0]    s1_col_r;
  logic             s1_last;

  logic [NKEYS-1:0] valid_r;
  logic [KW-1:0]    first_r, first_nxt;
  logic [KEY_W-1:0] key_num_r, key_num_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [DRV_W-1:0] out_drv_r, out_drv_nxt;
  logic [KEY_W-1:0] out_key_r, out_key_nxt;

  logic             in_acc, out_free, start_pass, load_acc, load_emit;

  logic [COLS+IN_W-1:0] lv_ext;
  logic [COLS-1:0]      raw_wdata, raw_rdata;
  logic [CNT_W:0]       cnt_wdata, cnt_rdata;
  logic [CNT_W-1:0]     cnt_cur, cnt_new;
  logic                 prs_cur, prs_new, smp;

  // One-hot drive, masked to the output width
  function automatic logic [DRV_W-1:0] drive_of(input logic [RA-1:0] r);
    logic [DRV_W-1:0] d;
    for (int i = 0; i < DRV_W; i++) begin
      d[i] = (int'(r) == i);
    end
    return d;
  endfunction

  assign last_row = (row_r == RA'(ROWS - 1));
  assign row_inc  = last_row ? '0 : row_r + RA'(1);
  assign in_acc   = in_valid & ~in_stall;
  assign out_free = ~out_valid_r | ~out_stall;
  assign s1_last  = s1_v_r & (s1_key_r == KA'(NKEYS - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc && last_row) state_nxt = ST_FILTER;
      ST_FILTER: if (s1_last) state_nxt = ST_EMIT;
      ST_EMIT:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall   = 1'b1;
    load_emit  = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_stall  = ~out_free;
      ST_FILTER: in_stall  = 1'b1;
      ST_EMIT:   load_emit = out_free;
      default:   in_stall  = 1'b1;
    endcase
    start_pass = in_acc & last_row;
    load_acc   = in_acc & ~last_row;
  end

  // Raw samples: one RAM row per matrix row, columns past the input read low
  assign lv_ext    = (COLS + IN_W)'(in_column_levels);
  assign raw_wdata = lv_ext[COLS-1:0];
  assign row_nxt   = in_acc ? row_inc : row_r;

  mksd_ram #(.W(COLS), .D(ROWS)) u_raw (
    .clk   (clk),
    .we    (in_acc),
    .waddr (row_r),
    .wdata (raw_wdata),
    .raddr (iss_row_r),
    .rdata (raw_rdata)
  );

  // Filter pass read side: walk keys in row-major order
  always_comb begin
    iss_busy_nxt = iss_busy_r;
    iss_key_nxt  = iss_key_r;
    iss_row_nxt  = iss_row_r;
    iss_col_nxt  = iss_col_r;
    if (start_pass) begin
      iss_busy_nxt = 1'b1;
      iss_key_nxt  = '0;
      iss_row_nxt  = '0;
      iss_col_nxt  = '0;
    end else if (iss_busy_r) begin
      iss_key_nxt = iss_key_r + KA'(1);
      if (iss_col_r == CA'(COLS - 1)) begin
        iss_col_nxt = '0;
        iss_row_nxt = iss_row_r + RA'(1);
      end else begin
        iss_col_nxt = iss_col_r + CA'(1);
      end
      if (iss_key_r == KA'(NKEYS - 1)) begin
        iss_busy_nxt = 1'b0;
      end
    end
  end

  // Counter and pressed flag per key, {pressed, counter}
  mksd_ram #(.W(CNT_W + 1), .D(NKEYS)) u_cnt (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_key_r),
    .wdata (cnt_wdata),
    .raddr (iss_key_r),
    .rdata (cnt_rdata)
  );

  // Integrating filter step; never-written entries read as zero
  always_comb begin
    cnt_cur = valid_r[s1_key_r] ? cnt_rdata[CNT_W-1:0] : '0;
    prs_cur = valid_r[s1_key_r] ? cnt_rdata[CNT_W] : 1'b0;
    smp     = raw_rdata[s1_col_r];
    cnt_new = cnt_cur;
    prs_new = prs_cur;
    if (smp) begin
      if (cnt_cur < deb_limit_r) cnt_new = cnt_cur + CNT_W'(1);
      else                       prs_new = 1'b1;
    end else begin
      if (cnt_cur != '0) cnt_new = cnt_cur - CNT_W'(1);
      else               prs_new = 1'b0;
    end
    cnt_wdata = {prs_new, cnt_new};
  end

  // First pressed key over the pass
  always_comb begin
    first_nxt   = first_r;
    key_num_nxt = key_num_r;
    if (start_pass) begin
      first_nxt = '0;
    end else if (s1_v_r && first_r == '0 && prs_new) begin
      first_nxt = KW'(s1_key_r) + KW'(1);
    end
    if (s1_last) begin
      key_num_nxt = KEY_W'(first_nxt);
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_drv_nxt   = out_drv_r;
    out_key_nxt   = out_key_r;
    if (load_acc) begin
      out_valid_nxt = 1'b1;
      out_drv_nxt   = drive_of(row_inc);
      out_key_nxt   = key_num_r;
    end else if (load_emit) begin
      out_valid_nxt = 1'b1;
      out_drv_nxt   = drive_of(row_r);
      out_key_nxt   = key_num_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      deb_limit_r <= DEB_LIMIT_RST;
      row_r       <= '0;
      iss_busy_r  <= 1'b0;
      s1_v_r      <= 1'b0;
      valid_r     <= '0;
      key_num_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      iss_busy_r  <= iss_busy_nxt;
      s1_v_r      <= iss_busy_r;
      key_num_r   <= key_num_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        deb_limit_r <= cfg_wdata;
      end
      if (s1_v_r) begin
        valid_r[s1_key_r] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    iss_key_r <= iss_key_nxt;
    iss_row_r <= iss_row_nxt;
    iss_col_r <= iss_col_nxt;
    s1_key_r  <= iss_key_r;
    s1_col_r  <= iss_col_r;
    first_r   <= first_nxt;
    out_drv_r <= out_drv_nxt;
    out_key_r <= out_key_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_row_drive  = out_drv_r;
  assign out_key_number = out_key_r;

endmodule

### src/mksd_chk.sv
// Port-level checker for the keypad scanner, bound to the top level.
`include "matrix_keypad_scan_debounce_assert.svh"

module mksd_chk import mksd_pkg::*; #(
  parameter int ROWS = 4,
  parameter int COLS = 4
) (
  input logic             clk,
  input logic             rst_n,
  input logic             cfg_we,
  input logic             in_valid,
  input logic             in_stall,
  input logic [IN_W-1:0]  in_column_levels,
  input logic             out_valid,
  input logic             out_stall,
  input logic [DRV_W-1:0] out_row_drive,
  input logic [KEY_W-1:0] out_key_number
);

  logic                   out_wait;
  logic                   in_wait;
  logic                   key_ok;
  logic [DRV_W+KEY_W-1:0] out_bus;

  assign out_wait = out_valid && out_stall;
  assign in_wait  = in_valid && in_stall;
  assign out_bus  = {out_row_drive, out_key_number};
  assign key_ok   = (ROWS * COLS > 31) || (int'(out_key_number) <= ROWS * COLS);

  // a stalled result holds
  `MKSD_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_bus), "result moved")

  // a stalled request holds
  `MKSD_ASSERT_NEXT(a_in_hold, in_wait, in_valid && $stable(in_column_levels), "request moved")

  // at most one row driven at a time
  `MKSD_ASSERT_IMPL(a_drive_onehot, out_valid, $onehot0(out_row_drive), "row drive not one-hot")

  // key number never beyond the matrix
  `MKSD_ASSERT_IMPL(a_key_range, out_valid, key_ok, "key number out of range")

  // limit written only with both channels quiet
  `MKSD_ASSERT_IMPL(a_cfg_idle, cfg_we, !in_valid && !out_valid, "limit write while busy")

endmodule

bind matrix_keypad_scan_debounce mksd_chk #(.ROWS(ROWS), .COLS(COLS)) u_chk (.*);

### verif/matrix_keypad_scan_debounce_test.sv
// Self-checking testbench for the keypad scanner with per-key debounce.
`timescale 1ns / 1ps

module matrix_keypad_scan_debounce_test;
  import mksd_pkg::*;

  localparam int ROWS = 4;
  localparam int COLS = 4;
  localparam int NKEYS = ROWS * COLS;
  // idle cycles before a limit write, after the last result is in
  localparam int SETTLE_CYCLES = NKEYS + 4;

  typedef enum logic [1:0] {
    REQ_SCAN,
    REQ_SENSE,
    REQ_DRAIN
  } req_kind_t;

  typedef struct {
    req_kind_t        kind;
    logic [IN_W-1:0]  levels;
    logic [CNT_W-1:0] sense;
  } scan_req_t;

  typedef struct {
    logic [DRV_W-1:0] row_drive;
    logic [KEY_W-1:0] key_number;
  } key_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [IN_W-1:0]  in_column_levels = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [DRV_W-1:0] out_row_drive;
  logic [KEY_W-1:0] out_key_number;

  // requests still to send, and results the scanner still owes
  scan_req_t   pending_reqs[$];
  key_result_t expected_keys[$];

  // scanner image kept by the predictor
  logic [1:0]       row_now;
  logic             raw_bits[NKEYS];
  logic [CNT_W-1:0] deb_cnt[NKEYS];
  logic             key_down[NKEYS];
  logic [CNT_W-1:0] sense_now;

  logic req_taken = 1'b0;
  int   gap_left = 0;
  int   send_calm = 0;
  int   stall_left = 0;
  int   stall_calm = 0;
  int   settle = 0;
  int   errors = 0;
  int   scans_taken = 0;
  int   results_seen = 0;
  int   pressed_seen = 0;
  int   sense_writes = 0;
  int   gen_items = 0;
  logic [1:0] gen_row = 2'd0;

  matrix_keypad_scan_debounce #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_column_levels(in_column_levels),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_drive   (out_row_drive),
    .out_key_number  (out_key_number)
  );

  always #5 clk = ~clk;

  // Idle length: mostly none, some short, a few long, with calm stretches.
  function automatic int pick_idle(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(30, 150);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One scan tick: store the row, filter all keys after the last row,
  // advance the row and report the first pressed key.
  function automatic void predict_scan_tick(input logic [IN_W-1:0] levels,
                                            output key_result_t res);
    for (int c = 0; c < COLS; c++)
      raw_bits[row_now * COLS + c] = levels[c];
    if (row_now == 2'(ROWS - 1)) begin
      for (int k = 0; k < NKEYS; k++) begin
        if (raw_bits[k]) begin
          if (deb_cnt[k] < sense_now) deb_cnt[k] = deb_cnt[k] + 1'b1;
          else key_down[k] = 1'b1;
        end else begin
          if (deb_cnt[k] != '0) deb_cnt[k] = deb_cnt[k] - 1'b1;
          else key_down[k] = 1'b0;
        end
      end
    end
    row_now = row_now + 1'b1;
    res.row_drive = '0;
    res.row_drive[row_now] = 1'b1;
    res.key_number = '0;
    for (int k = NKEYS - 1; k >= 0; k--)
      if (key_down[k]) res.key_number = KEY_W'(k + 1);
  endfunction

  // Request driver: scans with random gaps, limit writes and drains
  // only once the scanner has nothing left to return.
  always @(negedge clk) begin : drive_requests
    logic      next_we;
    scan_req_t head;
    next_we = 1'b0;
    if (rst_n && !(in_valid && !req_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        head = pending_reqs[0];
        case (head.kind)
          REQ_SCAN: begin
            in_column_levels <= head.levels;
            in_valid <= 1'b1;
            void'(pending_reqs.pop_front());
            gap_left = pick_idle(send_calm);
          end
          REQ_SENSE: begin
            in_valid <= 1'b0;
            if (expected_keys.size() != 0) begin
              settle = 0;
            end else if (settle < SETTLE_CYCLES) begin
              settle++;
            end else begin
              next_we = 1'b1;
              cfg_wdata <= head.sense;
              void'(pending_reqs.pop_front());
              settle = 0;
            end
          end
          default: begin
            in_valid <= 1'b0;
            if (expected_keys.size() == 0) void'(pending_reqs.pop_front());
          end
        endcase
      end
    end
    cfg_we <= next_we;
  end

  // Result side back-pressure
  always @(negedge clk) begin : drive_out_stall
    if (rst_n) begin
      if (stall_left == 0) stall_left = pick_idle(stall_calm);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: check results against the oldest expectation, then predict
  // for any request accepted at this edge.
  always @(posedge clk) begin : check_results
    key_result_t want;
    key_result_t next_res;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_key_number != '0) pressed_seen++;
        if (expected_keys.size() == 0) begin
          $error("unexpected result: row_drive %0h key_number %0d",
                 out_row_drive, out_key_number);
          errors++;
        end else begin
          want = expected_keys.pop_front();
          if (out_row_drive !== want.row_drive) begin
            $error("row_drive: expected %0h, actual %0h", want.row_drive, out_row_drive);
            errors++;
          end
          if (out_key_number !== want.key_number) begin
            $error("key_number: expected %0d, actual %0d",
                   want.key_number, out_key_number);
            errors++;
          end
        end
      end
      if (cfg_we) begin
        sense_now = cfg_wdata;
        sense_writes++;
      end
      if (in_valid && !in_stall) begin
        predict_scan_tick(in_column_levels, next_res);
        expected_keys.push_back(next_res);
        scans_taken++;
      end
    end
    req_taken <= rst_n && in_valid && !in_stall;
  end

  task automatic push_levels(input logic [IN_W-1:0] levels);
    scan_req_t r;
    r.kind = REQ_SCAN;
    r.levels = levels;
    r.sense = '0;
    pending_reqs.push_back(r);
    gen_items++;
    gen_row = gen_row + 1'b1;
  endtask

  task automatic push_sense(input logic [CNT_W-1:0] sense);
    scan_req_t r;
    r.kind = REQ_SENSE;
    r.levels = '0;
    r.sense = sense;
    pending_reqs.push_back(r);
  endtask

  task automatic push_drain();
    scan_req_t r;
    r.kind = REQ_DRAIN;
    r.levels = '0;
    r.sense = '0;
    pending_reqs.push_back(r);
  endtask

  // Hold a key pattern for whole scans, with optional contact bounce.
  task automatic push_scans(input logic [NKEYS-1:0] keys, input int scans,
                            input bit bounce);
    logic [IN_W-1:0] lv;
    for (int s = 0; s < scans * ROWS; s++) begin
      lv = keys[gen_row * COLS +: COLS];
      if (bounce && $urandom_range(0, 7) == 0) lv[$urandom_range(0, COLS - 1)] ^= 1'b1;
      push_levels(lv);
    end
  endtask

  initial begin : stimulus
    logic [NKEYS-1:0] keys;
    logic [CNT_W-1:0] sense;
    int               r;
    int               hold_max;

    row_now = '0;
    sense_now = DEB_LIMIT_RST;
    for (int k = 0; k < NKEYS; k++) begin
      raw_bits[k] = 1'b0;
      deb_cnt[k] = '0;
      key_down[k] = 1'b0;
    end

    // directed: walking column bits at the reset limit
    push_levels(4'h1);
    push_levels(4'h2);
    push_levels(4'h4);
    push_levels(4'h8);
    // zero limit: presses and releases take effect at once
    push_sense(8'd0);
    push_scans(16'hFFFF, 1, 1'b0);
    push_scans(16'h8000, 1, 1'b0);
    push_scans(16'hA5A5, 1, 1'b0);
    push_scans(16'h0000, 1, 1'b0);
    // max limit builds counters, then a lower limit leaves them above it
    push_sense(8'd255);
    push_scans(16'h0421, 12, 1'b0);
    push_sense(8'd3);
    push_scans(16'h0421, 1, 1'b0);
    push_scans(16'h0000, 4, 1'b0);
    push_drain();

    // random phases of held keys with bounce, releases and noise
    while (gen_items < 1024) begin
      r = $urandom_range(0, 9);
      if (r == 0) sense = 8'd0;
      else if (r == 1) sense = 8'd1;
      else if (r == 2) sense = CNT_W'($urandom_range(0, 255));
      else sense = CNT_W'($urandom_range(2, 6));
      push_sense(sense);
      hold_max = (sense > 10) ? 13 : int'(sense) + 3;
      repeat ($urandom_range(3, 8)) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          repeat ($urandom_range(1, 6)) push_levels(IN_W'($urandom_range(0, 15)));
        end else begin
          r = $urandom_range(0, 99);
          if (r < 50) keys = NKEYS'(1) << $urandom_range(0, NKEYS - 1);
          else if (r < 75)
            keys = (NKEYS'(1) << $urandom_range(0, NKEYS - 1)) |
                   (NKEYS'(1) << $urandom_range(0, NKEYS - 1));
          else if (r < 90) keys = '0;
          else keys = NKEYS'($urandom);
          push_scans(keys, $urandom_range(1, hold_max + 1), $urandom_range(0, 2) == 0);
        end
      end
      if ($urandom_range(0, 3) == 0) push_drain();
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid || expected_keys.size() != 0)
      @(posedge clk);
    repeat (NKEYS + 8) @(posedge clk);

    $display("Sent %0d scan requests over %0d limit writes.", scans_taken, sense_writes);
    $display("Checked %0d results, %0d of them with a key pressed.",
             results_seen, pressed_seen);
    if (errors == 0) begin
      $display("[matrix_keypad_scan_debounce] OK");
    end else begin
      $display("[matrix_keypad_scan_debounce] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #5_000_000;
    $display("[matrix_keypad_scan_debounce] ERROR");
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/mksd_pkg.sv
src/mksd_ram.sv
src/matrix_keypad_scan_debounce.sv
src/mksd_chk.sv
verif/matrix_keypad_scan_debounce_test.sv
